/* design/hce_pkg.sv */
// hce_pkg: shared widths, knot tables and pipeline payload types
// for the monotone hermite curve evaluator; no dependencies
package hce_pkg;

    // default output fraction bits and internal q.24 format
    localparam int FRAC_BITS_DEF = 12;
    localparam int IFRAC         = 24;
    localparam int SPEED_W       = 16;
    localparam int OUT_W         = 16;

    // internal widths: speed in q.24, t in [0, 1], extrapolation offset
    localparam int SW  = 32;
    localparam int DW  = SW + 1;
    localparam int TW  = IFRAC + 1;
    localparam int BW  = IFRAC + 4;
    localparam int EW  = 58;
    localparam int CW  = 27;
    localparam int NSEG = 4;

    // curve region of one request
    typedef enum logic [1:0] {
        MODE_HERM = 2'd0,
        MODE_LO   = 2'd1,
        MODE_HI   = 2'd2
    } t_mode;

    // knots, values and tangents in q.24
    localparam logic [CW-1:0] KNOT_X_FIRST = CW'(8388608);
    localparam logic [CW-1:0] KNOT_X_LAST  = CW'(67108864);
    localparam logic [CW-1:0] KNOT_Y_FIRST = CW'(11744051);
    localparam logic [CW-1:0] KNOT_Y_LAST  = CW'(26843546);
    localparam logic [CW-1:0] KNOT_M_FIRST = CW'(6710886);
    localparam logic [CW-1:0] KNOT_M_LAST  = CW'(5033165);

    // per segment: left knot, end values, tangent times spacing
    localparam logic [CW-1:0] SEG_XL [NSEG] = '{
        CW'(8388608), CW'(16777216), CW'(33554432), CW'(50331648)
    };
    localparam logic [CW-1:0] SEG_YL [NSEG] = '{
        CW'(11744051), CW'(15099494), CW'(18454938), CW'(21810381)
    };
    localparam logic [CW-1:0] SEG_YR [NSEG] = '{
        CW'(15099494), CW'(18454938), CW'(21810381), CW'(26843546)
    };
    localparam logic [CW-1:0] SEG_HM0 [NSEG] = '{
        CW'(3355443), CW'(5033165), CW'(3355443), CW'(4194304)
    };
    localparam logic [CW-1:0] SEG_HM1 [NSEG] = '{
        CW'(2516582), CW'(3355443), CW'(4194304), CW'(5033165)
    };

    // one in q.24 at basis width
    localparam logic signed [BW-1:0] ONE_Q = BW'(1) << IFRAC;

    // after segment search
    typedef struct packed {
        t_mode                 mode;
        logic [1:0]            seg;
        logic [TW-1:0]         t;
        logic signed [DW-1:0]  d;
    } t_seg;

    // after basis evaluation
    typedef struct packed {
        t_mode                 mode;
        logic [1:0]            seg;
        logic signed [BW-1:0]  b00;
        logic signed [BW-1:0]  b10;
        logic signed [BW-1:0]  b01;
        logic signed [BW-1:0]  b11;
        logic signed [EW-1:0]  ext;
    } t_basis;

endpackage

/* design/hce_seg.sv */
// hce_seg: first pipeline stage, finds the curve region and segment,
// forms t and the extrapolation offset; depends on hce_pkg
module hce_seg #(
    parameter int FRAC_BITS = hce_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [hce_pkg::SPEED_W-1:0]  i_speed_q,
    output logic                         o_valid,
    input  logic                         i_ready,
    output hce_pkg::t_seg                o_seg
);
    import hce_pkg::*;

    localparam int SHIFT = IFRAC - FRAC_BITS;

    logic [SW-1:0] s;
    logic [SW-1:0] diff;
    t_seg          n_seg;
    logic          r_vld;
    t_seg          r_seg;

    // widen speed to q.24
    assign s = SW'(i_speed_q) << SHIFT;

    // region and segment search, inner knot hits go left
    always_comb begin
        n_seg.mode = MODE_HERM;
        n_seg.seg  = 2'd0;
        n_seg.d    = $signed({1'b0, s}) - $signed(DW'(KNOT_X_FIRST));
        priority if (s <= SW'(SEG_XL[0])) begin
            n_seg.mode = MODE_LO;
        end else if (s >= SW'(KNOT_X_LAST)) begin
            n_seg.mode = MODE_HI;
            n_seg.d    = $signed({1'b0, s}) - $signed(DW'(KNOT_X_LAST));
        end else if (s <= SW'(SEG_XL[1])) begin
            n_seg.seg = 2'd0;
        end else if (s <= SW'(SEG_XL[2])) begin
            n_seg.seg = 2'd1;
        end else if (s <= SW'(SEG_XL[3])) begin
            n_seg.seg = 2'd2;
        end else begin
            n_seg.seg = 2'd3;
        end
        diff = s - SW'(SEG_XL[n_seg.seg]);
        // first segment is half wide: reciprocal of spacing is two
        if (n_seg.seg == 2'd0) begin
            n_seg.t = {diff[TW-2:0], 1'b0};
        end else begin
            n_seg.t = diff[TW-1:0];
        end
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_seg   = r_seg;

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_seg <= n_seg;
        end
    end

endmodule

/* design/hce_basis.sv */
// hce_basis: three pipeline stages, t squared with the extrapolation
// product, t cubed, then the four hermite basis terms; depends on hce_pkg
module hce_basis (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  hce_pkg::t_seg    i_seg,
    output logic             o_valid,
    input  logic             i_ready,
    output hce_pkg::t_basis  o_basis
);
    import hce_pkg::*;

    typedef struct packed {
        t_mode                 mode;
        logic [1:0]            seg;
        logic [TW-1:0]         t;
        logic [TW-1:0]         t2;
        logic signed [EW-1:0]  ext;
    } t_sq;

    typedef struct packed {
        t_mode                 mode;
        logic [1:0]            seg;
        logic [TW-1:0]         t;
        logic [TW-1:0]         t2;
        logic [TW-1:0]         t3;
        logic signed [EW-1:0]  ext;
    } t_cube;

    logic [2*TW-1:0]      sq_prod;
    logic [2*TW-1:0]      cube_prod;
    logic signed [EW-1:0] d_x;
    logic signed [EW-1:0] m_x;
    logic signed [BW-1:0] t1_s;
    logic signed [BW-1:0] t2_s;
    logic signed [BW-1:0] t3_s;
    t_sq                  n_sq;
    t_cube                n_cube;
    t_basis               n_basis;
    logic                 r_vld1;
    logic                 r_vld2;
    logic                 r_vld3;
    t_sq                  r_sq;
    t_cube                r_cube;
    t_basis               r_basis;
    logic                 rdy1;
    logic                 rdy2;
    logic                 rdy3;

    // stage 1: t squared and linear extrapolation product
    always_comb begin
        sq_prod    = (2*TW)'(i_seg.t) * (2*TW)'(i_seg.t);
        d_x        = EW'(i_seg.d);
        m_x        = (i_seg.mode == MODE_HI) ? $signed(EW'(KNOT_M_LAST))
                                             : $signed(EW'(KNOT_M_FIRST));
        n_sq.mode  = i_seg.mode;
        n_sq.seg   = i_seg.seg;
        n_sq.t     = i_seg.t;
        n_sq.t2    = sq_prod[IFRAC+TW-1:IFRAC];
        n_sq.ext   = d_x * m_x;
    end

    // stage 2: t cubed from the truncated square
    always_comb begin
        cube_prod   = (2*TW)'(r_sq.t2) * (2*TW)'(r_sq.t);
        n_cube.mode = r_sq.mode;
        n_cube.seg  = r_sq.seg;
        n_cube.t    = r_sq.t;
        n_cube.t2   = r_sq.t2;
        n_cube.t3   = cube_prod[IFRAC+TW-1:IFRAC];
        n_cube.ext  = r_sq.ext;
    end

    // stage 3: hermite basis terms
    always_comb begin
        t1_s         = $signed(BW'(r_cube.t));
        t2_s         = $signed(BW'(r_cube.t2));
        t3_s         = $signed(BW'(r_cube.t3));
        n_basis.mode = r_cube.mode;
        n_basis.seg  = r_cube.seg;
        n_basis.b00  = (t3_s <<< 1) - ((t2_s <<< 1) + t2_s) + ONE_Q;
        n_basis.b10  = t3_s - (t2_s <<< 1) + t1_s;
        n_basis.b01  = ((t2_s <<< 1) + t2_s) - (t3_s <<< 1);
        n_basis.b11  = t3_s - t2_s;
        n_basis.ext  = r_cube.ext;
    end

    // ready chain lets bubbles collapse
    assign rdy3    = !r_vld3 || i_ready;
    assign rdy2    = !r_vld2 || rdy3;
    assign rdy1    = !r_vld1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_vld3;
    assign o_basis = r_basis;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_vld1 <= i_valid;
            end
            if (rdy2) begin
                r_vld2 <= r_vld1;
            end
            if (rdy3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_sq <= n_sq;
        end
        if (rdy2) begin
            r_cube <= n_cube;
        end
        if (rdy3) begin
            r_basis <= n_basis;
        end
    end

endmodule

/* design/hce_sum.sv */
// hce_sum: two pipeline stages, basis times knot products, then sum,
// rounding and saturation into the output register; depends on hce_pkg
module hce_sum #(
    parameter int FRAC_BITS = hce_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  hce_pkg::t_basis            i_basis,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [hce_pkg::OUT_W-1:0]  o_time_mod_q,
    output logic                       o_saturated
);
    import hce_pkg::*;

    localparam int RSH = 2 * IFRAC - FRAC_BITS;

    typedef struct packed {
        t_mode                 mode;
        logic signed [EW-1:0]  p0;
        logic signed [EW-1:0]  p1;
        logic signed [EW-1:0]  p2;
        logic signed [EW-1:0]  p3;
        logic signed [EW-1:0]  ext;
    } t_prod;

    localparam logic [EW-1:0] HALF = EW'(1) << (RSH - 1);

    t_prod                n_prod;
    t_prod                r_prod;
    logic signed [EW-1:0] y_sum;
    logic [EW-1:0]        y_pos;
    logic [EW-1:0]        y_shr;
    logic                 n_sat;
    logic [OUT_W-1:0]     n_val;
    logic                 r_vld1;
    logic                 r_vld2;
    logic [OUT_W-1:0]     r_time_mod_q;
    logic                 r_saturated;
    logic                 rdy1;
    logic                 rdy2;

    // stage 1: four basis products against segment constants
    always_comb begin
        n_prod.mode = i_basis.mode;
        n_prod.ext  = i_basis.ext;
        n_prod.p0   = EW'(i_basis.b00) * $signed(EW'(SEG_YL[i_basis.seg]));
        n_prod.p1   = EW'(i_basis.b10) * $signed(EW'(SEG_HM0[i_basis.seg]));
        n_prod.p2   = EW'(i_basis.b01) * $signed(EW'(SEG_YR[i_basis.seg]));
        n_prod.p3   = EW'(i_basis.b11) * $signed(EW'(SEG_HM1[i_basis.seg]));
    end

    // stage 2: q.48 sum, clamp at zero, round half up, saturate
    always_comb begin
        if (r_prod.mode == MODE_HI) begin
            y_sum = ($signed(EW'(KNOT_Y_LAST)) <<< IFRAC) + r_prod.ext;
        end else if (r_prod.mode == MODE_LO) begin
            y_sum = ($signed(EW'(KNOT_Y_FIRST)) <<< IFRAC) + r_prod.ext;
        end else begin
            y_sum = r_prod.p0 + r_prod.p1 + r_prod.p2 + r_prod.p3;
        end
        y_pos = y_sum[EW-1] ? '0 : y_sum;
        y_shr = (y_pos + HALF) >> RSH;
        n_sat = |y_shr[EW-1:OUT_W];
        n_val = n_sat ? {OUT_W{1'b1}} : y_shr[OUT_W-1:0];
    end

    assign rdy2         = !r_vld2 || i_ready;
    assign rdy1         = !r_vld1 || rdy2;
    assign o_ready      = rdy1;
    assign o_valid      = r_vld2;
    assign o_time_mod_q = r_time_mod_q;
    assign o_saturated  = r_saturated;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_vld1 <= i_valid;
            end
            if (rdy2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    // stage payloads and output register
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_prod <= n_prod;
        end
        if (rdy2) begin
            r_time_mod_q <= n_val;
            r_saturated  <= n_sat;
        end
    end

endmodule

/* design/monotone_hermite_curve_eval.sv */
// Monotone cubic hermite speed curve: maps an unsigned speed to a time
// modifier through five fixed knots with linear extension past the ends.
// Input channel: i_valid / o_ready with i_speed_q, FRAC_BITS fraction bits.
// Output channel: o_valid / i_ready with o_time_mod_q (same format) and
// o_saturated, set when the result was clipped to all ones.
// Six register stages: segment search, t squared, t cubed, basis terms,
// basis products, sum and round. o_valid rises once a request reaches
// the last one. Throughput is one request per cycle while i_ready is high;
// no stage chains two multipliers, the widest being about 33 by 23 bits,
// so one multiply sets the clock.
// Every stage has its own valid bit and a ready chain: a stalled receiver
// holds the output register, while empty stages behind it keep taking
// requests until the pipeline is full. Nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers
// are not reset. The block has no state between requests.
// Uses hce_pkg, hce_seg, hce_basis and hce_sum.
module monotone_hermite_curve_eval #(
    parameter int FRAC_BITS = hce_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [hce_pkg::SPEED_W-1:0]  i_speed_q,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [hce_pkg::OUT_W-1:0]    o_time_mod_q,
    output logic                         o_saturated
);
    import hce_pkg::*;

    logic   seg_valid;
    logic   seg_ready;
    t_seg   seg_data;
    logic   basis_valid;
    logic   basis_ready;
    t_basis basis_data;

    // segment search and t
    hce_seg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_seg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_speed_q (i_speed_q),
        .o_valid   (seg_valid),
        .i_ready   (seg_ready),
        .o_seg     (seg_data)
    );

    // powers of t and basis terms
    hce_basis u_basis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (seg_valid),
        .o_ready (seg_ready),
        .i_seg   (seg_data),
        .o_valid (basis_valid),
        .i_ready (basis_ready),
        .o_basis (basis_data)
    );

    // products, sum and output register
    hce_sum #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (basis_valid),
        .o_ready      (basis_ready),
        .i_basis      (basis_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_time_mod_q (o_time_mod_q),
        .o_saturated  (o_saturated)
    );

endmodule

/* design/hce_checker.sv */
// hce_checker: port level assertions for the hermite curve evaluator,
// bound to the top level; depends on hce_pkg
module hce_checker #(
    parameter int FRAC_BITS = hce_pkg::FRAC_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic [hce_pkg::SPEED_W-1:0]  i_speed_q,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [hce_pkg::OUT_W-1:0]    o_time_mod_q,
    input logic                         o_saturated
);
    import hce_pkg::*;

    // curve minimum is one half at zero speed
    localparam logic [OUT_W-1:0] MIN_VAL = OUT_W'(1) << (FRAC_BITS - 1);

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a waiting request holds its payload
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_speed_q))
        else $error("waiting request changed");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_time_mod_q)
            && $stable(o_saturated))
        else $error("stalled result changed");

    // clipping flag matches the clipped value
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_time_mod_q == {OUT_W{1'b1}})
        else $error("saturated without full scale value");

    // results never fall below the curve minimum
    a_min_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_time_mod_q >= MIN_VAL)
        else $error("result below curve minimum");

endmodule

bind monotone_hermite_curve_eval hce_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_hce_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_speed_q    (i_speed_q),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_time_mod_q (o_time_mod_q),
    .o_saturated  (o_saturated)
);

/* test/tb_monotone_hermite_curve_eval.sv */
// tb_monotone_hermite_curve_eval: self-checking bench for the hermite speed curve
// drives speed requests through valid/ready, predicts each time modifier locally
// depends on hce_pkg and monotone_hermite_curve_eval
`timescale 1ns / 1ps

module tb_monotone_hermite_curve_eval;

    import hce_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int Q48_SHIFT   = 2 * IFRAC - FRAC;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 16;

    // one predicted result, region kept for the summary only
    typedef struct {
        logic [OUT_W-1:0] time_mod;
        logic             sat;
        t_mode            region;
    } t_mod_rec;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic [SPEED_W-1:0] i_speed_q = '0;
    logic               i_ready   = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [OUT_W-1:0]   o_time_mod_q;
    logic               o_saturated;

    t_mod_rec expected_mods[$];
    int       fail_count     = 0;
    int       checked_count  = 0;
    int       clipped_count  = 0;
    int       region_count[3] = '{0, 0, 0};
    int       in_stall_count = 0;

    // idling controls, set by the test tasks and the receiver
    bit gaps_on   = 1'b0;
    bit stalls_on = 1'b0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    monotone_hermite_curve_eval uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_speed_q    (i_speed_q),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_time_mod_q (o_time_mod_q),
        .o_saturated  (o_saturated)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // curve knots in q.24: speeds 0.5, 1, 2, 3, 4
    function automatic longint knot_speed(input int k);
        return (k == 0) ? 64'sd8388608 : 64'sd16777216 * k;
    endfunction

    function automatic longint knot_value(input int k);
        case (k)
            0:       return 64'sd11744051;
            1:       return 64'sd15099494;
            2:       return 64'sd18454938;
            3:       return 64'sd21810381;
            default: return 64'sd26843546;
        endcase
    endfunction

    function automatic longint knot_slope(input int k);
        case (k)
            0:       return 64'sd6710886;
            1:       return 64'sd5033165;
            2:       return 64'sd3355443;
            3:       return 64'sd4194304;
            default: return 64'sd5033165;
        endcase
    endfunction

    // cubic hermite on segment seg, result in q.48
    function automatic longint hermite_q48(input longint s, input int seg);
        longint span, t, t2, t3, hm0, hm1;
        longint b00, b10, b01, b11;
        span = (seg == 0) ? 64'sd8388608 : 64'sd16777216;
        t    = (s - knot_speed(seg)) * ((seg == 0) ? 2 : 1);
        t2   = (t * t) >>> IFRAC;
        t3   = (t2 * t) >>> IFRAC;
        hm0  = (span * knot_slope(seg)) >>> IFRAC;
        hm1  = (span * knot_slope(seg + 1)) >>> IFRAC;
        b00  = 2 * t3 - 3 * t2 + (64'sd1 <<< IFRAC);
        b10  = t3 - 2 * t2 + t;
        b01  = 3 * t2 - 2 * t3;
        b11  = t3 - t2;
        return b00 * knot_value(seg) + b10 * hm0 + b01 * knot_value(seg + 1) + b11 * hm1;
    endfunction

    // expected time modifier for one speed request
    function automatic t_mod_rec predict_time_mod(input logic [SPEED_W-1:0] speed);
        t_mod_rec rec;
        longint   s, y, r;
        int       seg;
        s = longint'(speed) <<< (IFRAC - FRAC);
        if (s <= knot_speed(0)) begin
            rec.region = MODE_LO;
            y = (knot_value(0) <<< IFRAC) + (s - knot_speed(0)) * knot_slope(0);
        end else if (s >= knot_speed(4)) begin
            rec.region = MODE_HI;
            y = (knot_value(4) <<< IFRAC) + (s - knot_speed(4)) * knot_slope(4);
        end else begin
            rec.region = MODE_HERM;
            // an exact inner knot falls in the segment to its left
            seg = 0;
            while (seg < 3 && s > knot_speed(seg + 1))
                seg++;
            y = hermite_q48(s, seg);
        end
        if (y < 0)
            y = 0;
        r = (y + (64'sd1 <<< (Q48_SHIFT - 1))) >>> Q48_SHIFT;
        if (r > 65535) begin
            rec.time_mod = '1;
            rec.sat      = 1'b1;
        end else begin
            rec.time_mod = r[OUT_W-1:0];
            rec.sat      = 1'b0;
        end
        return rec;
    endfunction

    // record accepted requests, then check results against the oldest expectation
    always @(posedge i_clk) begin
        t_mod_rec want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                want = predict_time_mod(i_speed_q);
                expected_mods.insert(expected_mods.size(), want);
                region_count[want.region]++;
                if (want.sat)
                    clipped_count++;
            end
            if (i_valid && !o_ready)
                in_stall_count++;
            if (o_valid && i_ready) begin
                if (expected_mods.size() == 0) begin
                    $display("%0t: unexpected result time_mod=%h sat=%b",
                             $time, o_time_mod_q, o_saturated);
                    fail_count++;
                end else begin
                    want = expected_mods.pop_front();
                    checked_count++;
                    if (o_time_mod_q !== want.time_mod) begin
                        $display("%0t: time_mod mismatch expected %h actual %h",
                                 $time, want.time_mod, o_time_mod_q);
                        fail_count++;
                    end
                    if (o_saturated !== want.sat) begin
                        $display("%0t: saturated mismatch expected %b actual %b",
                                 $time, want.sat, o_saturated);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver: random stalls plus a counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else if (stalls_on && $urandom_range(99) < 26) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // offer one request and wait for its handshake
    task automatic send_speed(input logic [SPEED_W-1:0] speed);
        int gap;
        if (gaps_on && $urandom_range(99) < 26) begin
            gap = $urandom_range(4, 1);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_speed_q <= speed;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_results;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_mods.size() != 0)
            @(posedge i_clk);
    endtask

    // speeds biased to the knots and the curved region
    function automatic logic [SPEED_W-1:0] pick_speed;
        int k;
        case ($urandom_range(3))
            0: return SPEED_W'($urandom_range(65535));
            1: return SPEED_W'($urandom_range(16400));
            2: begin
                k = $urandom_range(4);
                return SPEED_W'((k == 0 ? 2048 : 4096 * k) + $urandom_range(16) - 8);
            end
            default: return SPEED_W'($urandom_range(2047));
        endcase
    endfunction

    // knots exactly hit and one off either side, both ends, range extremes
    task automatic test_knot_points;
        logic [SPEED_W-1:0] pts[] = '{
            16'h0000, 16'h0001, 16'd2047, 16'd2048, 16'd2049, 16'd4095,
            16'd4096, 16'd4097, 16'd6144, 16'd8191, 16'd8192, 16'd8193,
            16'd12287, 16'd12288, 16'd12289, 16'd16383, 16'd16384, 16'd16385,
            16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF
        };
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        foreach (pts[i])
            send_speed(pts[i]);
        wait_results();
    endtask

    // random speeds with idling on both sides
    task automatic test_random_idle(input int count);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        repeat (count)
            send_speed(pick_speed());
        wait_results();
    endtask

    // back-to-back requests with the receiver always ready
    task automatic test_full_rate(input int count);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (count)
            send_speed(pick_speed());
        wait_results();
    endtask

    // receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_backpressure(input int count);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        hold_asks = hold_asks + 1;
        repeat (count)
            send_speed(pick_speed());
        wait_results();
    endtask

    // full range uniform speeds, every input bit toggles
    task automatic test_full_range(input int count);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        repeat (count)
            send_speed(SPEED_W'($urandom_range(65535)));
        wait_results();
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_knot_points();
        test_random_idle(450);
        test_full_rate(200);
        test_backpressure(60);
        test_full_range(300);
        test_random_idle(80);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("checked %0d results: %0d below first knot, %0d on curve, %0d past last knot",
                 checked_count, region_count[MODE_LO], region_count[MODE_HERM],
                 region_count[MODE_HI]);
        $display("%0d clipped, %0d cycles of input stalled by a full pipeline",
                 clipped_count, in_stall_count);
        if (fail_count == 0 && expected_mods.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (expected_mods.size() != 0)
                $display("%0t: %0d expected results never arrived",
                         $time, expected_mods.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("%0t: timeout", $time);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
design/hce_pkg.sv
design/hce_seg.sv
design/hce_basis.sv
design/hce_sum.sv
design/monotone_hermite_curve_eval.sv
design/hce_checker.sv
test/tb_monotone_hermite_curve_eval.sv
